// File: rtl/core/lu_factor_solve_defines.svh
// Assertion macros used by the checker file of the LU factor and solve block.
// Depends on nothing; the using module must have clk_i and rst_ni in scope.
`ifndef LU_FACTOR_SOLVE_DEFINES_SVH
`define LU_FACTOR_SOLVE_DEFINES_SVH

// Property checked at every rising clock edge outside reset.
`define LUF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen.
`define LUF_ASSERT_NEVER(lbl, cond, msg) \
  `LUF_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/core/luf_pkg.sv
// Shared types, constants and helpers of the LU factor and solve block.
// Depends on nothing; used by luf_div and lu_factor_solve.
package luf_pkg;

  localparam int unsigned MAX_ORDER = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_ORDER);
  localparam int unsigned ADDR_W    = 2 * IDX_W;
  localparam int unsigned ORDER_W   = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_STEPS = 48;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    MD_FU   = 2'd0,
    MD_FL   = 2'd1,
    MD_FWD  = 2'd2,
    MD_BACK = 2'd3
  } mode_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quot;
  } div_rsp_t;

  // Saturate a 64-bit signed value to the 32-bit signed range.
  function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic [DATA_W-1:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/luf_div.sv
// Iterative Q16.16 divider: (num * 2^16) / den, truncated toward zero, saturated.
// Depends on luf_pkg. One quotient bit per cycle, restoring algorithm.
module luf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  luf_pkg::div_req_t req_i,
  output luf_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [luf_pkg::DCNT_W-1:0]    cnt_q, cnt_d;
  logic [luf_pkg::DATA_W-1:0]    rem_q, rem_d;
  logic [luf_pkg::DIV_STEPS-1:0] quo_q, quo_d;
  logic [luf_pkg::DATA_W-1:0]    den_q, den_d;
  logic                          neg_q, neg_d;
  logic                          zero_q, zero_d;
  logic [luf_pkg::DATA_W-1:0]    res_q, res_d;

  logic [luf_pkg::DATA_W:0]      rem_sh;
  logic                          ge;
  logic [luf_pkg::DATA_W:0]      rem_sub;
  logic [luf_pkg::DIV_STEPS-1:0] q_fin;
  logic [luf_pkg::DATA_W-1:0]    num_abs, den_abs;

  assign num_abs = req_i.num[luf_pkg::DATA_W-1] ? (~req_i.num + 32'd1) : req_i.num;
  assign den_abs = req_i.den[luf_pkg::DATA_W-1] ? (~req_i.den + 32'd1) : req_i.den;
  assign rem_sh  = {rem_q, quo_q[luf_pkg::DIV_STEPS-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign q_fin   = {quo_q[luf_pkg::DIV_STEPS-2:0], ge};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    res_d  = res_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = luf_pkg::DCNT_W'(luf_pkg::DIV_STEPS - 1);
      rem_d  = '0;
      quo_d  = {num_abs, 16'd0};
      den_d  = den_abs;
      neg_d  = req_i.num[luf_pkg::DATA_W-1] ^ req_i.den[luf_pkg::DATA_W-1];
      zero_d = (req_i.den == '0);
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[luf_pkg::DATA_W-1:0] : rem_sh[luf_pkg::DATA_W-1:0];
      quo_d = q_fin;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (zero_q) begin
          res_d = '0;
        end else if (neg_q) begin
          res_d = (q_fin > 48'h0000_8000_0000) ? 32'h8000_0000
                                                : (~q_fin[luf_pkg::DATA_W-1:0] + 32'd1);
        end else begin
          res_d = (q_fin > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF
                                                : q_fin[luf_pkg::DATA_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = res_q;

endmodule

// File: rtl/core/lu_factor_solve.sv
// Top level of the LU factor and solve block: load, Doolittle factoring, substitution.
// Depends on luf_pkg and luf_div.
//
//  channel  | direction | word contents
//  s_axis   | in        | tdata: value[31:0]; tuser: func (0 matrix, 1 right-hand side)
//  m_axis   | out       | tdata: solution[31:0]; tlast: last_of_vector; tuser: zero_pivot
//  cfg      | in        | data: order[4:0]
//
// The last matrix word starts factoring on the single multiply-accumulate unit and the
// 48-step divider. The last right-hand-side word starts substitution (n divisions),
// then the n solution words leave one at a time, each held until taken.
// No word is taken while the block works or a solution word waits. Reset is
// asynchronous and active low; the matrix store and work vector are not cleared.
module lu_factor_solve (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [luf_pkg::DATA_W-1:0] s_axis_tdata,   // value[31:0]
  input  logic                       s_axis_tuser,   // func
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [luf_pkg::DATA_W-1:0] m_axis_tdata,   // solution[31:0]
  output logic                       m_axis_tlast,
  output logic                       m_axis_tuser,   // zero_pivot
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [luf_pkg::ORDER_W-1:0] cfg_data
);

  localparam int unsigned IW = luf_pkg::IDX_W;
  localparam int unsigned NW = luf_pkg::ORDER_W;
  localparam int unsigned DW = luf_pkg::DATA_W;

  // Sequencer states, one-hot.
  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_BASE   = 12'b0000_0000_0010,
    ST_BASE_W = 12'b0000_0000_0100,
    ST_TERM   = 12'b0000_0000_1000,
    ST_MUL    = 12'b0000_0001_0000,
    ST_ACC    = 12'b0000_0010_0000,
    ST_SUB    = 12'b0000_0100_0000,
    ST_DIV    = 12'b0000_1000_0000,
    ST_NEXT   = 12'b0001_0000_0000,
    ST_OUT_RD = 12'b0010_0000_0000,
    ST_OUT_W  = 12'b0100_0000_0000,
    ST_OUT_H  = 12'b1000_0000_0000
  } state_e;

  state_e          state_q, state_d;
  luf_pkg::mode_e  mode_q, mode_d;

  logic [NW-1:0] order_q, order_d;
  logic [IW-1:0] ld_row_q, ld_row_d;
  logic [IW-1:0] ld_col_q, ld_col_d;
  logic [IW-1:0] vidx_q, vidx_d;
  logic          factored_q, factored_d;
  logic          fault_q, fault_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] k_q, k_d;
  logic [NW-1:0] j_q, j_d;
  logic [IW-1:0] out_k_q, out_k_d;
  logic          m_valid_q, m_valid_d;

  logic [DW-1:0]        base_q, base_d;
  logic [DW-1:0]        piv_q, piv_d;
  logic signed [63:0]   acc_q, acc_d;
  logic signed [63:0]   prod_q, prod_d;
  logic [DW-1:0]        m_data_q, m_data_d;
  logic                 m_last_q, m_last_d;
  logic                 m_user_q, m_user_d;

  // Matrix store and work vector with registered reads.
  logic [DW-1:0] store_mem [luf_pkg::MAX_ORDER * luf_pkg::MAX_ORDER];
  logic [DW-1:0] vec_mem   [luf_pkg::MAX_ORDER];
  logic [DW-1:0] rda_q, rdb_q, rdv_q;

  logic [luf_pkg::ADDR_W-1:0] addr_a, addr_b, st_waddr;
  logic [IW-1:0]              vaddr, v_waddr;
  logic                       st_we, v_we;
  logic [DW-1:0]              st_wdata, v_wdata;

  luf_pkg::div_req_t div_req;
  luf_pkg::div_rsp_t div_rsp;

  logic [NW-1:0]      n;
  logic [IW-1:0]      n_m1;
  logic [IW-1:0]      r_idx, c_idx;
  logic               is_factor, needs_div;
  logic [NW-1:0]      j_start, j_end;
  logic [DW-1:0]      op_b;
  logic signed [63:0] sub_full;
  logic [DW-1:0]      sub_num;
  logic [DW-1:0]      res_val;
  logic               in_fire, cfg_fire, out_fire;
  logic [IW-1:0]      eff_row, eff_col;

  // Effective order: zero acts as one, anything above the store size as the maximum.
  always_comb begin
    if (order_q == '0) begin
      n = NW'(1);
    end else if (order_q > NW'(luf_pkg::MAX_ORDER)) begin
      n = NW'(luf_pkg::MAX_ORDER);
    end else begin
      n = order_q;
    end
  end
  assign n_m1 = IW'(n - 1'b1);

  assign is_factor = (mode_q == luf_pkg::MD_FU) || (mode_q == luf_pkg::MD_FL);
  assign needs_div = (mode_q == luf_pkg::MD_FL) || (mode_q == luf_pkg::MD_BACK);
  // For the lower factor the roles of row and column swap.
  assign r_idx     = (mode_q == luf_pkg::MD_FL) ? k_q : i_q;
  assign c_idx     = (mode_q == luf_pkg::MD_FL) ? i_q : k_q;
  assign j_start   = (mode_q == luf_pkg::MD_BACK) ? ({1'b0, i_q} + 1'b1) : '0;
  assign j_end     = (mode_q == luf_pkg::MD_BACK) ? n : {1'b0, i_q};
  assign op_b      = is_factor ? rdb_q : rdv_q;
  assign sub_full  = $signed({{32{base_q[DW-1]}}, base_q}) - acc_q;
  assign sub_num   = luf_pkg::sat32(sub_full);
  assign res_val   = needs_div ? div_rsp.quot : sub_num;

  assign cfg_ready     = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
  assign cfg_fire      = cfg_valid && cfg_ready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_valid_q && m_axis_tready;

  // A matrix word after factoring starts a fresh load.
  assign eff_row = factored_q ? '0 : ld_row_q;
  assign eff_col = factored_q ? '0 : ld_col_q;

  // Read address selection for the two store ports and the vector port.
  always_comb begin
    addr_a = {r_idx, c_idx};
    addr_b = {i_q, i_q};
    vaddr  = r_idx;
    unique case (state_q)
      ST_TERM: begin
        addr_a = {r_idx, j_q[IW-1:0]};
        addr_b = {j_q[IW-1:0], c_idx};
        vaddr  = j_q[IW-1:0];
      end
      ST_OUT_RD: begin
        vaddr = out_k_q;
      end
      default: begin
        vaddr = r_idx;
      end
    endcase
  end

  // Write port selection: loading comes from the input, results from the sequencer.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = {r_idx, c_idx};
    st_wdata = res_val;
    v_we     = 1'b0;
    v_waddr  = r_idx;
    v_wdata  = res_val;
    if (in_fire && !s_axis_tuser) begin
      st_we    = 1'b1;
      st_waddr = {eff_row, eff_col};
      st_wdata = s_axis_tdata;
    end else if (in_fire && s_axis_tuser && factored_q) begin
      v_we    = 1'b1;
      v_waddr = vidx_q;
      v_wdata = s_axis_tdata;
    end else if (((state_q == ST_SUB) && !needs_div) ||
                 ((state_q == ST_DIV) && div_rsp.done)) begin
      st_we = is_factor;
      v_we  = !is_factor;
    end
  end

  assign div_req.start = (state_q == ST_SUB) && needs_div;
  assign div_req.num   = sub_num;
  assign div_req.den   = piv_q;

  luf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    order_d    = order_q;
    ld_row_d   = ld_row_q;
    ld_col_d   = ld_col_q;
    vidx_d     = vidx_q;
    factored_d = factored_q;
    fault_d    = fault_q;
    i_d        = i_q;
    k_d        = k_q;
    j_d        = j_q;
    out_k_d    = out_k_q;
    m_valid_d  = m_valid_q;
    base_d     = base_q;
    piv_d      = piv_q;
    acc_d      = acc_q;
    prod_d     = prod_q;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    m_user_d   = m_user_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          order_d    = cfg_data;
          ld_row_d   = '0;
          ld_col_d   = '0;
          vidx_d     = '0;
          factored_d = 1'b0;
          fault_d    = 1'b0;
        end else if (in_fire && !s_axis_tuser) begin
          if (factored_q) begin
            factored_d = 1'b0;
            fault_d    = 1'b0;
          end
          if (eff_row == n_m1 && eff_col == n_m1) begin
            // Last element: factor in place, starting with row 0 of U.
            ld_row_d = '0;
            ld_col_d = '0;
            vidx_d   = '0;
            fault_d  = 1'b0;
            mode_d   = luf_pkg::MD_FU;
            i_d      = '0;
            k_d      = '0;
            state_d  = ST_BASE;
          end else if (eff_col == n_m1) begin
            ld_col_d = '0;
            ld_row_d = eff_row + 1'b1;
          end else begin
            ld_col_d = eff_col + 1'b1;
            ld_row_d = eff_row;
          end
        end else if (in_fire && factored_q) begin
          if (vidx_q == n_m1) begin
            vidx_d  = '0;
            mode_d  = luf_pkg::MD_FWD;
            i_d     = '0;
            state_d = ST_BASE;
          end else begin
            vidx_d = vidx_q + 1'b1;
          end
        end
      end
      ST_BASE: begin
        j_d     = j_start;
        acc_d   = '0;
        state_d = ST_BASE_W;
      end
      ST_BASE_W: begin
        base_d  = is_factor ? rda_q : rdv_q;
        piv_d   = rdb_q;
        state_d = (j_q < j_end) ? ST_TERM : ST_SUB;
      end
      ST_TERM: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        prod_d  = $signed(rda_q) * $signed(op_b);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        // Arithmetic shift rounds the product toward minus infinity.
        acc_d = acc_q + (prod_q >>> 16);
        j_d   = j_q + 1'b1;
        state_d = ((j_q + 1'b1) < j_end) ? ST_TERM : ST_SUB;
      end
      ST_SUB: begin
        if (needs_div) begin
          state_d = ST_DIV;
        end else begin
          if ((mode_q == luf_pkg::MD_FU) && (k_q == i_q) && (sub_num == '0)) begin
            fault_d = 1'b1;
          end
          state_d = ST_NEXT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        unique case (mode_q)
          luf_pkg::MD_FU: begin
            if (k_q != n_m1) begin
              k_d     = k_q + 1'b1;
              state_d = ST_BASE;
            end else if (i_q != n_m1) begin
              mode_d  = luf_pkg::MD_FL;
              k_d     = i_q + 1'b1;
              state_d = ST_BASE;
            end else begin
              factored_d = 1'b1;
              state_d    = ST_IDLE;
            end
          end
          luf_pkg::MD_FL: begin
            if (k_q != n_m1) begin
              k_d = k_q + 1'b1;
            end else begin
              mode_d = luf_pkg::MD_FU;
              i_d    = i_q + 1'b1;
              k_d    = i_q + 1'b1;
            end
            state_d = ST_BASE;
          end
          luf_pkg::MD_FWD: begin
            if (i_q != n_m1) begin
              i_d = i_q + 1'b1;
            end else begin
              mode_d = luf_pkg::MD_BACK;
              i_d    = n_m1;
            end
            state_d = ST_BASE;
          end
          luf_pkg::MD_BACK: begin
            if (i_q != '0) begin
              i_d     = i_q - 1'b1;
              state_d = ST_BASE;
            end else begin
              out_k_d = '0;
              state_d = ST_OUT_RD;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_W;
      end
      ST_OUT_W: begin
        m_valid_d = 1'b1;
        m_data_d  = rdv_q;
        m_last_d  = (out_k_q == n_m1);
        m_user_d  = fault_q;
        state_d   = ST_OUT_H;
      end
      ST_OUT_H: begin
        if (out_fire) begin
          m_valid_d = 1'b0;
          if (out_k_q == n_m1) begin
            state_d = ST_IDLE;
          end else begin
            out_k_d = out_k_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mode_q     <= luf_pkg::MD_FU;
      order_q    <= NW'(luf_pkg::MAX_ORDER);
      ld_row_q   <= '0;
      ld_col_q   <= '0;
      vidx_q     <= '0;
      factored_q <= 1'b0;
      fault_q    <= 1'b0;
      i_q        <= '0;
      k_q        <= '0;
      j_q        <= '0;
      out_k_q    <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      order_q    <= order_d;
      ld_row_q   <= ld_row_d;
      ld_col_q   <= ld_col_d;
      vidx_q     <= vidx_d;
      factored_q <= factored_d;
      fault_q    <= fault_d;
      i_q        <= i_d;
      k_q        <= k_d;
      j_q        <= j_d;
      out_k_q    <= out_k_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    piv_q    <= piv_d;
    acc_q    <= acc_d;
    prod_q   <= prod_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_user_q <= m_user_d;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    rda_q <= store_mem[addr_a];
    rdb_q <= store_mem[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vec_mem[v_waddr] <= v_wdata;
    end
    rdv_q <= vec_mem[vaddr];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// File: rtl/core/luf_checker.sv
// Port-level checks of the LU factor and solve block, bound to the top level.
// Depends on lu_factor_solve_defines.svh and lu_factor_solve.
`include "lu_factor_solve_defines.svh"

module luf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic m_axis_tlast,
  input logic cfg_ready
);

  // A waiting solution word stays offered until taken.
  `LUF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped")

  // No input word is taken while a solution word waits.
  `LUF_ASSERT_NEVER(a_no_in_while_out, m_axis_tvalid && s_axis_tready, "input taken during output")

  // Input readiness implies the block is idle, so configuration is open too.
  `LUF_ASSERT(a_in_implies_cfg, s_axis_tready |-> cfg_ready, "input ready while busy")

  // After the last word of a vector the output side is empty again.
  `LUF_ASSERT(a_last_empties, m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid,
    "output valid after last word")

endmodule

bind lu_factor_solve luf_checker u_luf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tlast  (m_axis_tlast),
  .cfg_ready     (cfg_ready)
);

// File: tb/sv/testbench.sv
// Self-checking testbench for the LU factor and solve block.
// Depends on luf_pkg and lu_factor_solve; it predicts every solution word and checks the stream.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_ORDER   = luf_pkg::MAX_ORDER;
  localparam int unsigned DATA_W      = luf_pkg::DATA_W;
  localparam int unsigned ORDER_W     = luf_pkg::ORDER_W;
  localparam int unsigned IDLE_LIMIT  = 60000;
  localparam int unsigned FACTOR_WAIT = 12000;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned WORD_TARGET = 370;
  localparam logic        FUNC_MATRIX = 1'b0;
  localparam logic        FUNC_RHS    = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] solution;
    logic              last_of_vector;
    logic              zero_pivot;
  } solution_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [DATA_W-1:0]  m_axis_tdata;
  logic               m_axis_tlast;
  logic               m_axis_tuser;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ORDER_W-1:0] cfg_data = '0;

  // Mirror of the block state used to predict solutions.
  logic signed [31:0] lu_mem [0:MAX_ORDER*MAX_ORDER-1];
  logic signed [31:0] vec_mem [0:MAX_ORDER-1];
  int unsigned        load_pos;
  bit                 is_factored;
  bit                 pivot_zero;
  logic [ORDER_W-1:0] order_reg;

  solution_word_t     solution_q [$];
  int unsigned        words_sent;
  int unsigned        mismatches;
  bit                 no_gaps;
  int unsigned        hold_ask;
  int unsigned        hold_done;

  lu_factor_solve u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Q16.16 helpers: saturation, floor-rounded product, truncating quotient.
  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic longint q_mul(logic signed [31:0] a, logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] q_div(logic signed [31:0] num,
                                               logic signed [31:0] den);
    if (den == 0) return 32'sd0;
    return clamp32((longint'(num) * 65536) / longint'(den));
  endfunction

  function automatic int unsigned active_order();
    if (order_reg == 0) return 1;
    if (order_reg > MAX_ORDER) return MAX_ORDER;
    return 32'(order_reg);
  endfunction

  // In-place Doolittle factoring of the mirrored matrix.
  task automatic factor_matrix(int unsigned n);
    longint s;
    logic signed [31:0] num;
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned k = i; k < n; k++) begin
        s = 0;
        for (int unsigned j = 0; j < i; j++) begin
          s += q_mul(lu_mem[i*MAX_ORDER+j], lu_mem[j*MAX_ORDER+k]);
        end
        lu_mem[i*MAX_ORDER+k] = clamp32(longint'(lu_mem[i*MAX_ORDER+k]) - s);
      end
      if (lu_mem[i*MAX_ORDER+i] == 0) pivot_zero = 1'b1;
      for (int unsigned k = i + 1; k < n; k++) begin
        s = 0;
        for (int unsigned j = 0; j < i; j++) begin
          s += q_mul(lu_mem[k*MAX_ORDER+j], lu_mem[j*MAX_ORDER+i]);
        end
        num = clamp32(longint'(lu_mem[k*MAX_ORDER+i]) - s);
        lu_mem[k*MAX_ORDER+i] = q_div(num, lu_mem[i*MAX_ORDER+i]);
      end
    end
  endtask

  // Forward then back substitution; queues the n solution words.
  task automatic solve_vector(int unsigned n);
    longint s;
    logic signed [31:0] num;
    solution_word_t w;
    for (int unsigned i = 0; i < n; i++) begin
      s = 0;
      for (int unsigned j = 0; j < i; j++) s += q_mul(lu_mem[i*MAX_ORDER+j], vec_mem[j]);
      vec_mem[i] = clamp32(longint'(vec_mem[i]) - s);
    end
    for (int i = int'(n) - 1; i >= 0; i--) begin
      s = 0;
      for (int unsigned j = i + 1; j < n; j++) s += q_mul(lu_mem[i*MAX_ORDER+j], vec_mem[j]);
      num = clamp32(longint'(vec_mem[i]) - s);
      vec_mem[i] = q_div(num, lu_mem[i*MAX_ORDER+i]);
    end
    for (int unsigned k = 0; k < n; k++) begin
      w.solution       = vec_mem[k];
      w.last_of_vector = (k == n - 1);
      w.zero_pivot     = pivot_zero;
      solution_q.push_back(w);
    end
  endtask

  // Updates the mirror for one accepted input word.
  task automatic predict_word(logic func, logic signed [31:0] v);
    int unsigned n;
    n = active_order();
    if (func == FUNC_MATRIX) begin
      if (is_factored) begin
        is_factored = 1'b0;
        pivot_zero  = 1'b0;
        load_pos    = 0;
      end
      if (load_pos >= n * n) load_pos = 0;
      lu_mem[(load_pos / n) * MAX_ORDER + (load_pos % n)] = v;
      load_pos++;
      if (load_pos == n * n) begin
        pivot_zero = 1'b0;
        factor_matrix(n);
        is_factored = 1'b1;
        load_pos    = 0;
      end
    end else if (is_factored) begin
      if (load_pos >= n) load_pos = 0;
      vec_mem[load_pos] = v;
      load_pos++;
      if (load_pos == n) begin
        load_pos = 0;
        solve_vector(n);
      end
    end
  endtask

  // Sends one word, with a random gap before it unless gaps are switched off.
  task automatic send_word(logic func, logic [31:0] v);
    int unsigned gap;
    gap = 0;
    if (!no_gaps) begin
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= func;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_word(func, v);
    words_sent++;
  endtask

  task automatic drop_valid();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes the order register once the block has gone quiet.
  task automatic write_order(logic [ORDER_W-1:0] v);
    // The last word is taken already; stop offering it.
    s_axis_tvalid <= 1'b0;
    while (solution_q.size() != 0) @(posedge clk_i);
    // A loaded matrix may still be factoring even though no word is due.
    repeat (FACTOR_WAIT) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid   <= 1'b0;
    order_reg   = v;
    load_pos    = 0;
    is_factored = 1'b0;
    pivot_zero  = 1'b0;
  endtask

  function automatic logic [31:0] pick_value(bit wide, bit diag, int unsigned n);
    logic [31:0] mag;
    if (wide) return $urandom;
    if (diag) begin
      mag = n * 32'h0001_0000 + $urandom_range(0, 32'h0004_0000);
      return $urandom_range(0, 1) ? mag : -mag;
    end
    return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
  endfunction

  task automatic send_matrix(int unsigned n, bit wide);
    for (int unsigned r = 0; r < n; r++) begin
      for (int unsigned c = 0; c < n; c++) send_word(FUNC_MATRIX, pick_value(wide, r == c, n));
    end
  endtask

  task automatic send_vector(int unsigned n, bit wide);
    for (int unsigned i = 0; i < n; i++) begin
      send_word(FUNC_RHS, wide ? $urandom : $urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
    end
  endtask

  // Order one with the extreme values on both kinds of word.
  task automatic test_single_order();
    write_order(5'd1);
    send_word(FUNC_MATRIX, 32'h8000_0000);
    send_word(FUNC_RHS,    32'h7FFF_FFFF);
    send_word(FUNC_RHS,    32'h8000_0000);
    send_word(FUNC_MATRIX, 32'h7FFF_FFFF);
    send_word(FUNC_RHS,    32'h8000_0000);
    send_word(FUNC_MATRIX, 32'h0000_0001);
    send_word(FUNC_RHS,    32'h7FFF_FFFF);
    send_word(FUNC_RHS,    32'hFFFF_FFFF);
  endtask

  // Order zero behaves as one; a zero matrix is a zero pivot.
  task automatic test_order_zero();
    write_order(5'd0);
    send_word(FUNC_MATRIX, 32'h0000_0000);
    send_word(FUNC_RHS,    32'h0001_0000);
  endtask

  // A zero first pivot, then a zero last pivot.
  task automatic test_zero_pivot();
    write_order(5'd2);
    send_word(FUNC_MATRIX, 32'h0000_0000);
    send_word(FUNC_MATRIX, 32'h0001_0000);
    send_word(FUNC_MATRIX, 32'h0001_0000);
    send_word(FUNC_MATRIX, 32'h0001_0000);
    send_vector(2, 1'b0);
    for (int i = 0; i < 4; i++) send_word(FUNC_MATRIX, 32'h0001_0000);
    send_vector(2, 1'b0);
  endtask

  // Right-hand-side words before factoring are ignored; a matrix word
  // mid-vector throws away the factors and the partial vector.
  task automatic test_broken_sequences();
    write_order(5'd2);
    send_word(FUNC_RHS, 32'h0003_0000);
    send_word(FUNC_RHS, 32'h0004_0000);
    send_matrix(2, 1'b0);
    send_word(FUNC_RHS, 32'h0005_0000);
    send_matrix(2, 1'b0);
    send_vector(2, 1'b0);
  endtask

  // Order above the maximum acts as the maximum; no gaps while the matrix is sent.
  task automatic test_max_order();
    write_order(5'd31);
    no_gaps = 1'b1;
    send_matrix(MAX_ORDER, 1'b0);
    no_gaps = 1'b0;
    send_vector(MAX_ORDER, 1'b0);
    send_vector(MAX_ORDER, 1'b1);
  endtask

  // The receiver holds off while several vectors are offered.
  task automatic test_back_pressure();
    write_order(5'd4);
    send_matrix(4, 1'b0);
    hold_ask++;
    for (int i = 0; i < 5; i++) send_vector(4, 1'b0);
  endtask

  // Random orders, mostly well-formed systems, some noise and broken runs.
  task automatic test_random_systems();
    int unsigned n;
    int unsigned vecs;
    while (words_sent < WORD_TARGET) begin
      write_order(ORDER_W'($urandom_range(1, 6)));
      n = active_order();
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) send_vector(n, 1'b1);
      send_matrix(n, $urandom_range(0, 4) == 0);
      vecs = $urandom_range(1, 5);
      for (int unsigned v = 0; v < vecs; v++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(FUNC_RHS, $urandom);
          send_matrix(n, 1'b1);
        end
        send_vector(n, $urandom_range(0, 3) == 0);
      end
      no_gaps = 1'b0;
    end
  endtask

  // Receiver: random short and long stalls, plus a requested long hold-off.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    hold_done  = 0;
    forever begin
      @(posedge clk_i);
      if (hold_done != hold_ask) begin
        hold_done  = hold_ask;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 2) begin
        stall_left = $urandom_range(20, 60);
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < 15) begin
        stall_left = 0;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Checks each solution word against the oldest predicted one.
  always @(posedge clk_i) begin
    solution_word_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (solution_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: data %h last %b pivot %b",
                                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want = solution_q.pop_front();
        if (m_axis_tdata !== want.solution || m_axis_tlast !== want.last_of_vector ||
            m_axis_tuser !== want.zero_pivot) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h/%b/%b got %h/%b/%b",
                                         want.solution, want.last_of_vector, want.zero_pivot,
                                         m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end
      end
    end
  end

  // Watchdog on cycles with no word moving on any channel.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    words_sent  = 0;
    mismatches  = 0;
    no_gaps     = 1'b0;
    hold_ask    = 0;
    load_pos    = 0;
    is_factored = 1'b0;
    pivot_zero  = 1'b0;
    order_reg   = 5'd16;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_order();
    test_order_zero();
    test_zero_pivot();
    test_broken_sequences();
    test_max_order();
    test_back_pressure();
    test_random_systems();
    drop_valid();
    while (solution_q.size() != 0) @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (mismatches == 0 && solution_q.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
